// ===== rtl/core/afk_pkg.sv =====
// shared constants, widths and the arctangent table for the arm forward kinematics
// no dependencies
package afk_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int LANES = 3;            // shoulder angle, shoulder plus elbow, base
  localparam int ANG_W = 30;           // angle in 2^-24 rad before wrapping
  localparam int RES_W = 28;           // angle residual inside the rotator
  localparam int XY_W  = 33;           // rotator vector, q1.30 with headroom
  localparam int OUT_W = 19;

  localparam logic signed [ANG_W-1:0] ANG_PI       = 30'sd52707179;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI  = 30'sd26353589;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI   = 30'sd105414358;
  localparam logic signed [ANG_W-1:0] ANG_Q23_BASE = 30'sd26353590;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN  = 33'sd652032874;

  localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
  localparam logic [1:0] REG_UPPER_LINK  = 2'd1;
  localparam logic [1:0] REG_LOWER_LINK  = 2'd2;

  function automatic logic signed [RES_W-1:0] atan_val(input int idx);
    logic signed [RES_W-1:0] v;
    unique case (idx)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/afk_angle_prep.sv =====
// joint mapping, wrap into [-pi, pi] and fold into [-pi/2, pi/2], four stages
// depends on afk_pkg
module afk_angle_prep (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid_in,
  input  logic signed [15:0]                  base_angle,
  input  logic signed [15:0]                  shoulder_angle,
  input  logic signed [15:0]                  elbow_angle,
  input  logic                                en_in,
  output logic                                en_out,
  output logic                                valid_out,
  output logic signed [afk_pkg::RES_W-1:0]    res [afk_pkg::LANES],
  output logic                                neg [afk_pkg::LANES]
);

  logic [4:1] v;
  logic [4:1] en;
  logic signed [afk_pkg::ANG_W-1:0] a1 [afk_pkg::LANES];
  logic signed [afk_pkg::ANG_W-1:0] a2 [afk_pkg::LANES];
  logic signed [afk_pkg::ANG_W-1:0] a3 [afk_pkg::LANES];
  logic signed [afk_pkg::ANG_W-1:0] sh_s;
  logic signed [afk_pkg::ANG_W-1:0] se_s;
  logic signed [afk_pkg::ANG_W-1:0] ba_s;

  assign en[4]  = !v[4] || en_in;
  assign en[3]  = !v[3] || en[4];
  assign en[2]  = !v[2] || en[3];
  assign en[1]  = !v[1] || en[2];
  assign en_out = en[1];
  assign valid_out = v[4];

  assign ba_s = afk_pkg::ANG_W'(base_angle) <<< 11;
  assign sh_s = afk_pkg::ANG_W'(shoulder_angle) <<< 11;
  assign se_s = (afk_pkg::ANG_W'(shoulder_angle) + afk_pkg::ANG_W'(elbow_angle)) <<< 11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= valid_in;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a1[0] <= afk_pkg::ANG_PI - sh_s;
      a1[1] <= afk_pkg::ANG_Q23_BASE - se_s;
      a1[2] <= ba_s;
    end
    for (int l = 0; l < afk_pkg::LANES; l++) begin
      if (en[2]) begin
        if (a1[l] > afk_pkg::ANG_PI) a2[l] <= a1[l] - afk_pkg::ANG_TWO_PI;
        else if (a1[l] < -afk_pkg::ANG_PI) a2[l] <= a1[l] + afk_pkg::ANG_TWO_PI;
        else a2[l] <= a1[l];
      end
      if (en[3]) begin
        if (a2[l] > afk_pkg::ANG_PI) a3[l] <= a2[l] - afk_pkg::ANG_TWO_PI;
        else if (a2[l] < -afk_pkg::ANG_PI) a3[l] <= a2[l] + afk_pkg::ANG_TWO_PI;
        else a3[l] <= a2[l];
      end
      if (en[4]) begin
        if (a3[l] > afk_pkg::ANG_HALF_PI) begin
          res[l] <= afk_pkg::RES_W'(a3[l] - afk_pkg::ANG_PI);
          neg[l] <= 1'b1;
        end else if (a3[l] < -afk_pkg::ANG_HALF_PI) begin
          res[l] <= afk_pkg::RES_W'(a3[l] + afk_pkg::ANG_PI);
          neg[l] <= 1'b1;
        end else begin
          res[l] <= afk_pkg::RES_W'(a3[l]);
          neg[l] <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/afk_cordic.sv =====
// unrolled rotation-mode cordic, one register stage per iteration, three lanes
// depends on afk_pkg
module afk_cordic #(
  parameter int STAGES = afk_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid_in,
  input  logic signed [afk_pkg::RES_W-1:0]    res [afk_pkg::LANES],
  input  logic                                neg_in [afk_pkg::LANES],
  input  logic                                en_in,
  output logic                                en_out,
  output logic                                valid_out,
  output logic signed [afk_pkg::XY_W-1:0]     x_out [afk_pkg::LANES],
  output logic signed [afk_pkg::XY_W-1:0]     y_out [afk_pkg::LANES],
  output logic                                neg_out [afk_pkg::LANES]
);

  logic [STAGES:1] v;
  logic [STAGES:1] en;
  logic signed [afk_pkg::XY_W-1:0]  xs [1:STAGES][afk_pkg::LANES];
  logic signed [afk_pkg::XY_W-1:0]  ys [1:STAGES][afk_pkg::LANES];
  logic signed [afk_pkg::RES_W-1:0] as [1:STAGES][afk_pkg::LANES];
  logic                             ns [1:STAGES][afk_pkg::LANES];

  assign en_out = en[1];
  assign valid_out = v[STAGES];

  // a stage may load when it or some stage after it is empty, or when the next block takes the output
  always_comb begin
    logic room;
    room = en_in;
    for (int k = STAGES; k >= 1; k--) begin
      room = room || !v[k];
      en[k] = room;
    end
  end

  always_comb begin
    for (int l = 0; l < afk_pkg::LANES; l++) begin
      x_out[l] = xs[STAGES][l];
      y_out[l] = ys[STAGES][l];
      neg_out[l] = ns[STAGES][l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= valid_in;
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < afk_pkg::LANES; l++) begin
      // first iteration starts from (gain, 0), so x stays at the gain
      if (en[1]) begin
        ns[1][l] <= neg_in[l];
        xs[1][l] <= afk_pkg::CORDIC_GAIN;
        if (res[l] >= 0) begin
          ys[1][l] <= afk_pkg::CORDIC_GAIN;
          as[1][l] <= res[l] - afk_pkg::atan_val(0);
        end else begin
          ys[1][l] <= -afk_pkg::CORDIC_GAIN;
          as[1][l] <= res[l] + afk_pkg::atan_val(0);
        end
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          ns[k][l] <= ns[k-1][l];
          if (as[k-1][l] >= 0) begin
            xs[k][l] <= xs[k-1][l] - (ys[k-1][l] >>> (k-1));
            ys[k][l] <= ys[k-1][l] + (xs[k-1][l] >>> (k-1));
            as[k][l] <= as[k-1][l] - afk_pkg::atan_val(k-1);
          end else begin
            xs[k][l] <= xs[k-1][l] + (ys[k-1][l] >>> (k-1));
            ys[k][l] <= ys[k-1][l] - (xs[k-1][l] >>> (k-1));
            as[k][l] <= as[k-1][l] + afk_pkg::atan_val(k-1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/afk_arm_math.sv =====
// link products, reach and height sums, base rotation, rounding and saturation
// depends on afk_pkg
module afk_arm_math (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid_in,
  input  logic signed [afk_pkg::XY_W-1:0]     x_in [afk_pkg::LANES],
  input  logic signed [afk_pkg::XY_W-1:0]     y_in [afk_pkg::LANES],
  input  logic                                neg_in [afk_pkg::LANES],
  input  logic [15:0]                         a1,
  input  logic [15:0]                         a2,
  input  logic [15:0]                         a3,
  input  logic                                en_in,
  output logic                                en_out,
  output logic                                valid_out,
  output logic signed [afk_pkg::OUT_W-1:0]    tip_x,
  output logic signed [afk_pkg::OUT_W-1:0]    tip_y,
  output logic signed [afk_pkg::OUT_W-1:0]    tip_z
);

  function automatic logic signed [afk_pkg::OUT_W-1:0] sat(input logic signed [31:0] val);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd262143;
    lo = -32'sd262144;
    if (val > hi) return afk_pkg::OUT_W'(hi);
    if (val < lo) return afk_pkg::OUT_W'(lo);
    return afk_pkg::OUT_W'(val);
  endfunction

  logic [4:1] v;
  logic [4:1] en;
  logic signed [afk_pkg::XY_W-1:0] c2, c23, s2, s23, cb, sb;
  logic signed [16:0] a2_s, a3_s;
  logic signed [49:0] p2c, p3c, p2s, p3s;
  logic signed [afk_pkg::XY_W-1:0] cb1, sb1, cb2, sb2;
  logic signed [50:0] rsum, zsum;
  logic signed [34:0] r;
  logic signed [21:0] z2, z3;
  logic signed [67:0] px, py;
  logic signed [67:0] pxr, pyr;

  assign en[4] = !v[4] || en_in;
  assign en[3] = !v[3] || en[4];
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en_out = en[1];
  assign valid_out = v[4];

  // fold undo: negate sine and cosine
  assign c2  = neg_in[0] ? -x_in[0] : x_in[0];
  assign s2  = neg_in[0] ? -y_in[0] : y_in[0];
  assign c23 = neg_in[1] ? -x_in[1] : x_in[1];
  assign s23 = neg_in[1] ? -y_in[1] : y_in[1];
  assign cb  = neg_in[2] ? -x_in[2] : x_in[2];
  assign sb  = neg_in[2] ? -y_in[2] : y_in[2];
  assign a2_s = $signed({1'b0, a2});
  assign a3_s = $signed({1'b0, a3});

  assign rsum = 51'(p2c) + 51'(p3c) + 51'sd32768;
  assign zsum = 51'(p2s) + 51'(p3s) + 51'sd536870912;
  assign pxr  = px + (68'sd1 <<< 43);
  assign pyr  = py + (68'sd1 <<< 43);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= valid_in;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2c <= a2_s * c2;
      p3c <= a3_s * c23;
      p2s <= a2_s * s2;
      p3s <= a3_s * s23;
      cb1 <= cb;
      sb1 <= sb;
    end
    if (en[2]) begin
      r   <= 35'(rsum >>> 16);
      z2  <= 22'(zsum >>> 30) + $signed({6'd0, a1});
      cb2 <= cb1;
      sb2 <= sb1;
    end
    if (en[3]) begin
      px <= r * cb2;
      py <= r * sb2;
      z3 <= z2;
    end
    if (en[4]) begin
      tip_x <= sat(32'(pxr >>> 44));
      tip_y <= sat(32'(pyr >>> 44));
      tip_z <= sat(32'(z3));
    end
  end

endmodule

// ===== rtl/core/arm_forward_kinematics.sv =====
// three-joint arm forward kinematics: joint angles in, tool tip x, y, z out
// from accepted word to output word the data passes the angle prep, cordic and arm math stages
// throughput one word per cycle while out_stall is low; a stalled output only holds stages that are full
// synchronous active-high reset clears all valid bits and the link registers to zero
// depends on afk_pkg, afk_angle_prep, afk_cordic, afk_arm_math
module arm_forward_kinematics #(
  parameter int CORDIC_STAGES = afk_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] base_angle,
  input  logic signed [15:0] shoulder_angle,
  input  logic signed [15:0] elbow_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] tip_x,
  output logic signed [18:0] tip_y,
  output logic signed [18:0] tip_z
);

  logic [15:0] base_height;
  logic [15:0] upper_link_length;
  logic [15:0] lower_link_length;

  logic prep_en, prep_valid, cordic_en, cordic_valid, math_en;
  logic signed [afk_pkg::RES_W-1:0] prep_res [afk_pkg::LANES];
  logic                             prep_neg [afk_pkg::LANES];
  logic signed [afk_pkg::XY_W-1:0]  cx [afk_pkg::LANES];
  logic signed [afk_pkg::XY_W-1:0]  cy [afk_pkg::LANES];
  logic                             cneg [afk_pkg::LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height       <= '0;
      upper_link_length <= '0;
      lower_link_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        afk_pkg::REG_BASE_HEIGHT: base_height       <= cfg_data;
        afk_pkg::REG_UPPER_LINK:  upper_link_length <= cfg_data;
        afk_pkg::REG_LOWER_LINK:  lower_link_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !prep_en;

  afk_angle_prep u_prep (
    .clk            (clk),
    .rst            (rst),
    .valid_in       (in_valid),
    .base_angle     (base_angle),
    .shoulder_angle (shoulder_angle),
    .elbow_angle    (elbow_angle),
    .en_in          (cordic_en),
    .en_out         (prep_en),
    .valid_out      (prep_valid),
    .res            (prep_res),
    .neg            (prep_neg)
  );

  afk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (prep_valid),
    .res       (prep_res),
    .neg_in    (prep_neg),
    .en_in     (math_en),
    .en_out    (cordic_en),
    .valid_out (cordic_valid),
    .x_out     (cx),
    .y_out     (cy),
    .neg_out   (cneg)
  );

  afk_arm_math u_math (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (cordic_valid),
    .x_in      (cx),
    .y_in      (cy),
    .neg_in    (cneg),
    .a1        (base_height),
    .a2        (upper_link_length),
    .a3        (lower_link_length),
    .en_in     (!out_stall),
    .en_out    (math_en),
    .valid_out (out_valid),
    .tip_x     (tip_x),
    .tip_y     (tip_y),
    .tip_z     (tip_z)
  );

  // input can only be held back when the whole pipe is full
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("input stalled with room in pipe");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tip_x) && $stable(tip_z))
    else $error("output word lost under stall");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid) else $error("output valid straight after reset");

endmodule
